// ----- rtl/core/mdt_pkg.sv -----
// ----------------------------------------------------------------------------
// mdt_pkg
// Shared types and codes for the micro-op dependency tracker.
// ----------------------------------------------------------------------------
package mdt_pkg;

  localparam int unsigned SEQ_W        = 64;
  localparam int unsigned MAX_DEPS_DEF = 8;

  // configuration register indexes
  localparam logic [1:0] CFG_OWN_SEQ       = 2'd0;
  localparam logic [1:0] CFG_TYPE_OFFSET   = 2'd1;
  localparam logic [1:0] CFG_INTRA_INITIAL = 2'd2;

  // operation codes
  localparam logic [1:0] MODE_GET    = 2'd0;
  localparam logic [1:0] MODE_ADD    = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_RANGE     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;

  typedef struct packed {
    logic [1:0]       mode;
    logic [SEQ_W-1:0] seq_value;
    logic [6:0]       dep_index;
  } mdt_in_t;

  typedef struct packed {
    logic [SEQ_W-1:0] dep_value;
    logic [2:0]       status;
    logic [3:0]       list_count;
    logic [5:0]       intra_left;
  } mdt_out_t;

endpackage

// ----- rtl/core/mdt_dep_ram.sv -----
// ----------------------------------------------------------------------------
// mdt_dep_ram
// Explicit dependency list store: one write and one read port, registered read.
// ----------------------------------------------------------------------------
module mdt_dep_ram
  import mdt_pkg::*;
#(
  parameter int unsigned DEPTH = MAX_DEPS_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [SEQ_W-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [SEQ_W-1:0] rdata_o
);

  logic [SEQ_W-1:0] mem_q [DEPTH];
  logic [SEQ_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/microop_dependency_tracker_core.sv -----
// ----------------------------------------------------------------------------
// microop_dependency_tracker_core
// Dependency list of one micro-op: implicit intra-instruction run plus an
// explicit list of producer sequence numbers held in a small RAM.
// ----------------------------------------------------------------------------
// One word in, one word out per operation, one operation at a time. A get
// passes from decode to done, through a RAM read state when it reads the list
// RAM. Add and list-path remove scan the list RAM one entry a cycle, then
// resolve; an add on an empty list skips the scan, a list-path remove on an
// empty list skips scan and resolve. An intra remove that moves k run entries
// into the list writes one entry a cycle; a rejected intra remove goes from its
// decode state straight to done. A new word is accepted while the previous
// result still waits at the output register; its own result then holds until
// the output register is free. Writes to the configuration port are expected
// only while no operation is in progress.
module microop_dependency_tracker_core
  import mdt_pkg::*;
#(
  parameter int unsigned MAX_DEPS = MAX_DEPS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [SEQ_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  mdt_in_t          in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output mdt_out_t         out_data_o
);

  localparam int unsigned AW = $clog2(MAX_DEPS);
  localparam int unsigned CW = $clog2(MAX_DEPS + 1);
  localparam int unsigned SW = CW + 7;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECODE  = 4'd1;
  localparam logic [3:0] S_GETRD   = 4'd2;
  localparam logic [3:0] S_SCAN    = 4'd3;
  localparam logic [3:0] S_RESOLVE = 4'd4;
  localparam logic [3:0] S_RMDEC   = 4'd5;
  localparam logic [3:0] S_MOVE    = 4'd6;
  localparam logic [3:0] S_DONE    = 4'd7;

  // configuration
  logic [SEQ_W-1:0] own_seq_q;
  logic [5:0]       type_offset_q;

  // state
  logic [3:0]       state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic [5:0]       intra_q, intra_d;

  // current word
  logic [1:0]       mode_q;
  logic [SEQ_W-1:0] seq_q;
  logic [6:0]       idx_q;
  logic [SEQ_W-1:0] base_q, base_d;
  logic [SEQ_W:0]   diff_q, diff_d;

  // scan
  logic [CW-1:0]    scan_ptr_q, scan_ptr_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [AW-1:0]    cmp_idx_q, cmp_idx_d;
  logic             found_q, found_d;
  logic [AW-1:0]    match_idx_q, match_idx_d;
  logic [SEQ_W-1:0] last_val_q, last_val_d;
  logic             last_match_q, last_match_d;

  // run move
  logic [5:0]       mv_left_q, mv_left_d;
  logic [SEQ_W-1:0] mv_val_q, mv_val_d;

  // result
  logic [SEQ_W-1:0] res_val_q, res_val_d;
  logic [2:0]       res_st_q, res_st_d;
  logic             out_valid_q, out_valid_d;
  mdt_out_t         out_data_q, out_data_d;

  // RAM port
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [SEQ_W-1:0] ram_wdata, ram_rdata;

  logic             accept;
  logic [6:0]       off_sum;
  logic [6:0]       rel_idx;
  logic [CW-1:0]    cnt_m1;
  logic [SW-1:0]    move_end;
  logic             hit;

  mdt_dep_ram #(
    .DEPTH (MAX_DEPS),
    .AW    (AW)
  ) u_dep_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign off_sum  = {1'b0, type_offset_q} + {1'b0, intra_q};
  assign rel_idx  = idx_q - {1'b0, intra_q};
  assign cnt_m1   = count_q - 1'b1;
  assign move_end = SW'(count_q) + SW'(diff_q[5:0]);
  assign hit      = (ram_rdata == seq_q);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    intra_d      = intra_q;
    base_d       = base_q;
    diff_d       = diff_q;
    scan_ptr_d   = scan_ptr_q;
    cmp_vld_d    = 1'b0;
    cmp_idx_d    = cmp_idx_q;
    found_d      = found_q;
    match_idx_d  = match_idx_q;
    last_val_d   = last_val_q;
    last_match_d = last_match_q;
    mv_left_d    = mv_left_q;
    mv_val_d     = mv_val_q;
    res_val_d    = res_val_q;
    res_st_d     = res_st_q;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    ram_we       = 1'b0;
    ram_waddr    = count_q[AW-1:0];
    ram_wdata    = mv_val_q;
    ram_re       = 1'b0;
    ram_raddr    = scan_ptr_q[AW-1:0];

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          base_d  = own_seq_q - SEQ_W'(off_sum);
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        res_val_d  = '0;
        res_st_d   = ST_OK;
        scan_ptr_d = '0;
        found_d    = 1'b0;
        unique case (mode_q)
          MODE_GET: begin
            if (idx_q < {1'b0, intra_q}) begin
              res_val_d = base_q + SEQ_W'(idx_q);
              state_d   = S_DONE;
            end else if (8'(rel_idx) < 8'(count_q)) begin
              ram_re    = 1'b1;
              ram_raddr = rel_idx[AW-1:0];
              state_d   = S_GETRD;
            end else begin
              res_st_d = ST_RANGE;
              state_d  = S_DONE;
            end
          end
          MODE_ADD: begin
            state_d = (count_q == '0) ? S_RESOLVE : S_SCAN;
          end
          MODE_REMOVE: begin
            diff_d  = {1'b0, seq_q} - {1'b0, base_q};
            state_d = S_RMDEC;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end

      S_GETRD: begin
        res_val_d = ram_rdata;
        state_d   = S_DONE;
      end

      S_RMDEC: begin
        if (diff_q[SEQ_W]) begin
          // below the run: explicit list
          if (count_q == '0) begin
            res_st_d = ST_EMPTY;
            state_d  = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end else if ((|diff_q[SEQ_W-1:6]) || (diff_q[5:0] >= intra_q)) begin
          res_st_d = ST_NOT_FOUND;
          state_d  = S_DONE;
        end else if ((diff_q[5:0] != '0) && (move_end >= SW'(MAX_DEPS))) begin
          res_st_d = ST_FULL;
          state_d  = S_DONE;
        end else if (diff_q[5:0] == '0) begin
          intra_d = intra_q - 6'd1;
          state_d = S_DONE;
        end else begin
          mv_left_d = diff_q[5:0];
          mv_val_d  = base_q;
          state_d   = S_MOVE;
        end
      end

      S_MOVE: begin
        // leading run entries go to the list tail, one a cycle
        ram_we    = 1'b1;
        count_d   = count_q + 1'b1;
        mv_val_d  = mv_val_q + 1'b1;
        mv_left_d = mv_left_q - 6'd1;
        if (mv_left_q == 6'd1) begin
          intra_d = intra_q - diff_q[5:0] - 6'd1;
          state_d = S_DONE;
        end
      end

      S_SCAN: begin
        // read issue runs one entry ahead of the compare
        if (scan_ptr_q < count_q) begin
          ram_re     = 1'b1;
          scan_ptr_d = scan_ptr_q + 1'b1;
          cmp_vld_d  = 1'b1;
          cmp_idx_d  = scan_ptr_q[AW-1:0];
        end
        if (cmp_vld_q) begin
          if (hit && !found_q) begin
            found_d     = 1'b1;
            match_idx_d = cmp_idx_q;
          end
          if (cmp_idx_q == cnt_m1[AW-1:0]) begin
            last_val_d   = ram_rdata;
            last_match_d = hit;
            state_d      = S_RESOLVE;
          end
        end
      end

      S_RESOLVE: begin
        state_d = S_DONE;
        if (mode_q == MODE_ADD) begin
          if (found_q) begin
            res_st_d = ST_OK;
          end else if (count_q >= CW'(MAX_DEPS)) begin
            res_st_d = ST_FULL;
          end else begin
            ram_we    = 1'b1;
            ram_wdata = seq_q;
            count_d   = count_q + 1'b1;
          end
        end else begin
          if (last_match_q) begin
            count_d = cnt_m1;
          end else if (found_q) begin
            ram_we    = 1'b1;
            ram_waddr = match_idx_q;
            ram_wdata = last_val_q;
            count_d   = cnt_m1;
          end else begin
            res_st_d = ST_NOT_FOUND;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d           = 1'b1;
          out_data_d.dep_value  = (res_st_q == ST_OK) ? res_val_q : '0;
          out_data_d.status     = res_st_q;
          out_data_d.list_count = 4'(count_q);
          out_data_d.intra_left = intra_q;
          state_d               = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // intra_initial write reloads the run length
    if (cfg_we_i && (cfg_idx_i == CFG_INTRA_INITIAL)) begin
      intra_d = cfg_wdata_i[5:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      count_q       <= '0;
      intra_q       <= '0;
      out_valid_q   <= 1'b0;
      cmp_vld_q     <= 1'b0;
      own_seq_q     <= '0;
      type_offset_q <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      intra_q     <= intra_d;
      out_valid_q <= out_valid_d;
      cmp_vld_q   <= cmp_vld_d;
      if (cfg_we_i && (cfg_idx_i == CFG_OWN_SEQ)) begin
        own_seq_q <= cfg_wdata_i;
      end
      if (cfg_we_i && (cfg_idx_i == CFG_TYPE_OFFSET)) begin
        type_offset_q <= cfg_wdata_i[5:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= in_data_i.mode;
      seq_q  <= in_data_i.seq_value;
      idx_q  <= in_data_i.dep_index;
    end
    base_q       <= base_d;
    diff_q       <= diff_d;
    scan_ptr_q   <= scan_ptr_d;
    cmp_idx_q    <= cmp_idx_d;
    found_q      <= found_d;
    match_idx_q  <= match_idx_d;
    last_val_q   <= last_val_d;
    last_match_q <= last_match_d;
    mv_left_q    <= mv_left_d;
    mv_val_q     <= mv_val_d;
    res_val_q    <= res_val_d;
    res_st_q     <= res_st_d;
    out_data_q   <= out_data_d;
  end

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_DEPS))
    else $error("list count above capacity");

  a_move_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOVE) |-> (count_q < CW'(MAX_DEPS)))
    else $error("run move writes past list end");

  a_intra_no_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cfg_we_i && (cfg_idx_i == CFG_INTRA_INITIAL)) |=> (intra_q <= $past(intra_q)))
    else $error("intra count grew without a config write");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ((count_q == $past(count_q)) || (count_q == $past(count_q) + 1'b1)
              || (count_q == $past(count_q) - 1'b1)))
    else $error("list count moved by more than one");
`endif

endmodule

// ----- tb/tb_microop_dependency_tracker_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_microop_dependency_tracker_core
// Drives get, add, remove and unused-mode words through the tracker under several settings
// of own_seq, type_offset and intra_initial, predicts every result word from a
// local copy of the dependency state and checks each field in order.
// ----------------------------------------------------------------------------
module tb_microop_dependency_tracker_core;
  import mdt_pkg::*;

  localparam int unsigned DEPTH      = MAX_DEPS_DEF;
  localparam int unsigned LIMIT      = 300000;
  localparam int unsigned N_PHASES   = 12;
  localparam int unsigned PHASE_OPS  = 50;
  localparam logic [1:0]  CFG_UNUSED = 2'd3;
  localparam logic [1:0]  MODE_IDLE  = 2'd3;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [1:0]       cfg_idx_i;
  logic [SEQ_W-1:0] cfg_wdata_i;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  mdt_in_t          in_data_i   = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  mdt_out_t         out_data_o;

  microop_dependency_tracker_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // local copy of the tracker state
  logic [63:0] own_seq_q;
  logic [5:0]  type_off_q;
  int unsigned intra_q;
  logic [63:0] list_mem [DEPTH];
  int unsigned list_len;

  mdt_in_t     op_q [$];
  mdt_out_t    reply_q [$];
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned faults;
  int unsigned cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] run_start();
    return own_seq_q - 64'(type_off_q) - 64'(intra_q);
  endfunction

  // apply one word to the local state and return the result it should give
  function automatic mdt_out_t track_op(mdt_in_t w);
    mdt_out_t    r;
    logic [63:0] base;
    logic [63:0] k;
    int unsigned i;
    int unsigned hit;
    r        = '0;
    r.status = ST_OK;
    base     = run_start();
    case (w.mode)
      MODE_GET: begin
        if (w.dep_index < intra_q) begin
          r.dep_value = base + 64'(w.dep_index);
        end else if (w.dep_index - intra_q < list_len) begin
          r.dep_value = list_mem[w.dep_index - intra_q];
        end else begin
          r.status = ST_RANGE;
        end
      end
      MODE_ADD: begin
        hit = 0;
        for (i = 0; i < list_len; i++)
          if (list_mem[i] == w.seq_value) hit = 1;
        if (hit == 0) begin
          if (list_len >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            list_mem[list_len] = w.seq_value;
            list_len++;
          end
        end
      end
      MODE_REMOVE: begin
        if (w.seq_value >= base) begin
          // intra path: leading run entries move into the list
          k = w.seq_value - base;
          if (k >= 64'(intra_q)) begin
            r.status = ST_NOT_FOUND;
          end else if (k != 0 && 64'(list_len) + k >= 64'(DEPTH)) begin
            r.status = ST_FULL;
          end else begin
            for (i = 0; i < int'(k); i++) begin
              list_mem[list_len] = base + 64'(i);
              list_len++;
            end
            intra_q = intra_q - int'(k) - 1;
          end
        end else if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          hit = list_len;
          if (list_mem[list_len-1] == w.seq_value) begin
            hit = list_len - 1;
          end else begin
            for (i = 0; i < list_len; i++)
              if (hit == list_len && list_mem[i] == w.seq_value) hit = i;
          end
          if (hit == list_len) begin
            r.status = ST_NOT_FOUND;
          end else begin
            list_mem[hit]        = list_mem[list_len-1];
            list_mem[list_len-1] = w.seq_value;
            list_len--;
          end
        end
      end
      default: ;
    endcase
    if (r.status != ST_OK) r.dep_value = '0;
    r.list_count = 4'(list_len);
    r.intra_left = 6'(intra_q);
    return r;
  endfunction

  function automatic void push_op(logic [1:0] m, logic [63:0] s, logic [6:0] idx);
    mdt_in_t w;
    w.mode      = m;
    w.seq_value = s;
    w.dep_index = idx;
    op_q.push_back(w);
    items_sent++;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_OWN_SEQ:       own_seq_q  = val;
      CFG_TYPE_OFFSET:   type_off_q = val[5:0];
      CFG_INTRA_INITIAL: intra_q    = int'(val[5:0]);
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (results_seen != items_sent) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // random words, mostly aimed at live run entries and list entries
  task automatic gen_random(input int unsigned n);
    int unsigned sel;
    int unsigned pick;
    logic [63:0] base;
    logic [63:0] v;
    logic [6:0]  idx;
    repeat (n) begin
      while (op_q.size() > 1) @(posedge clk_i);
      base = run_start();
      v    = rand64();
      idx  = 7'($urandom_range(0, 127));
      sel  = $urandom_range(0, 99);
      if (sel < 25) begin
        if (sel < 20) idx = 7'($urandom_range(0, intra_q + list_len));
        push_op(MODE_GET, v, idx);
      end else if (sel < 55) begin
        pick = $urandom_range(0, 9);
        if (pick < 4) v = base - 64'($urandom_range(1, 48));
        else if (pick < 6 && list_len > 0) v = list_mem[$urandom_range(0, list_len-1)];
        else if (pick < 8) v = 64'($urandom_range(0, 15));
        push_op(MODE_ADD, v, idx);
      end else begin
        pick = $urandom_range(0, 19);
        if (pick < 7 && intra_q > 0) begin
          v = base + 64'($urandom_range(0, intra_q));
        end else if (pick < 14 && list_len > 0) begin
          v = (pick < 10) ? list_mem[list_len-1] : list_mem[$urandom_range(0, list_len-1)];
        end else if (pick < 17) begin
          v = base - 64'($urandom_range(1, 48));
        end
        push_op(MODE_REMOVE, v, idx);
      end
    end
  endtask

  // sender: bursts of back-to-back words with random gaps
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      burst_left = 4;
      gap_left   = 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (op_q.size() != 0) begin
        in_data_i  <= op_q.pop_front();
        in_valid_i <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: stall pattern is redrawn periodically from four modes
  int unsigned rdy_tick;
  int unsigned rdy_mode;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rdy_tick = 0;
      rdy_mode = 0;
    end else begin
      rdy_tick++;
      if (rdy_tick % 128 == 0) rdy_mode = $urandom_range(0, 3);
      case (rdy_mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= 1'($urandom_range(0, 1));
        2:       out_ready_i <= (rdy_tick % 4 == 0);
        default: out_ready_i <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  task automatic report_bad(input string what, input mdt_out_t want, input mdt_out_t got);
    faults++;
    if (faults <= 10)
      $display("%0t: %s: exp val=%h st=%0d cnt=%0d intra=%0d got val=%h st=%0d cnt=%0d intra=%0d",
               $realtime, what, want.dep_value, want.status, want.list_count, want.intra_left,
               got.dep_value, got.status, got.list_count, got.intra_left);
  endtask

  always @(posedge clk_i) begin
    mdt_out_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) reply_q.push_back(track_op(in_data_i));
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (reply_q.size() == 0) begin
          report_bad("unexpected word", '0, out_data_o);
        end else begin
          want = reply_q.pop_front();
          if (out_data_o.dep_value !== want.dep_value || out_data_o.status !== want.status ||
              out_data_o.list_count !== want.list_count ||
              out_data_o.intra_left !== want.intra_left)
            report_bad("mismatch", want, out_data_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [63:0] own;
    logic [5:0]  off;
    logic [5:0]  intra;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_OWN_SEQ;
    cfg_wdata_i  = '0;
    own_seq_q    = '0;
    type_off_q   = '0;
    intra_q      = 0;
    list_len     = 0;
    items_sent   = 0;
    results_seen = 0;
    faults       = 0;
    cycles       = 0;
    for (int i = 0; i < DEPTH; i++) list_mem[i] = '1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // run of three ending at 997
    write_reg(CFG_OWN_SEQ, 64'd1000);
    write_reg(CFG_TYPE_OFFSET, 64'd2);
    write_reg(CFG_INTRA_INITIAL, 64'd3);
    write_reg(CFG_UNUSED, rand64());
    push_op(MODE_GET, '0, 7'd0);
    push_op(MODE_GET, '1, 7'd2);
    push_op(MODE_GET, '0, 7'd3);         // past both parts
    push_op(MODE_GET, '0, 7'd127);
    push_op(MODE_REMOVE, 64'd500, 7'd0); // list path on empty list
    push_op(MODE_ADD, 64'd100, 7'd0);
    push_op(MODE_ADD, 64'd100, 7'd0);    // already listed
    push_op(MODE_ADD, 64'd0, 7'd0);
    push_op(MODE_ADD, 64'd200, 7'd0);
    push_op(MODE_GET, '0, 7'd3);
    push_op(MODE_REMOVE, 64'd100, 7'd0); // swap with last
    push_op(MODE_REMOVE, 64'd0, 7'd0);   // last entry
    push_op(MODE_REMOVE, 64'd300, 7'd0); // not listed
    push_op(MODE_REMOVE, 64'd998, 7'd0); // past the run
    push_op(MODE_REMOVE, 64'd996, 7'd0); // moves one run entry
    push_op(MODE_REMOVE, 64'd997, 7'd0);
    push_op(MODE_IDLE, rand64(), 7'h7f);
    push_op(MODE_ADD, '1, 7'h7f);
    for (int i = 1; i <= 6; i++) push_op(MODE_ADD, 64'(i), 7'd0); // last one hits full
    wait_drained();

    // list full while the run still has entries
    write_reg(CFG_INTRA_INITIAL, 64'd5);
    push_op(MODE_REMOVE, 64'd994, 7'd0);
    push_op(MODE_ADD, 64'd200, 7'd0);
    push_op(MODE_REMOVE, 64'd993, 7'd0);
    push_op(MODE_GET, '0, 7'd127);
    wait_drained();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin own = '1; off = 6'd63; intra = 6'd63; end
        1: begin own = '0; off = 6'd63; intra = 6'd63; end
        2: begin own = '0; off = 6'd0;  intra = 6'd0;  end
        3: begin own = '1; off = 6'd0;  intra = 6'd1;  end
        default: begin
          own   = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 200)) : rand64();
          off   = 6'($urandom);
          intra = 6'($urandom);
        end
      endcase
      write_reg(CFG_OWN_SEQ, own);
      write_reg(CFG_TYPE_OFFSET, 64'(off));
      write_reg(CFG_INTRA_INITIAL, 64'(intra));
      gen_random(PHASE_OPS);
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (reply_q.size() != 0) faults++;
    if (faults == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
